// ===== design/assert_macros.svh =====
// assertion macros for the divider calculation rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge outside reset
`define SDC_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("sdc assertion failed");

// antecedent at one edge implies consequent at the next edge
`define SDC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sdc assertion failed");

`endif

// ===== design/sdc_pkg.sv =====
// types and constants for the synthesizer divider calculation block
// no dependencies; used by sdc_core, the top level and the testbench
`default_nettype none

package sdc_pkg;

  localparam logic [12:0] TOP_MHZ       = 13'd5400;
  localparam logic [15:0] HIGH_VCO      = 16'd3200;
  localparam logic [2:0]  MAX_EXP       = 3'd5;
  localparam logic [15:0] RECIP5        = 16'd52429;
  localparam logic [16:0] HZ_MULT       = 17'd78125;
  localparam logic [4:0]  HZ_SHIFT_BASE = 5'd14;

  localparam int DIV_BITS  = 41;
  localparam int DIV_STEPS = 2;
  localparam int MUL_BITS  = 17;
  localparam int FRAC_W    = DIV_BITS - 5;
  localparam int ACC_W     = FRAC_W + MUL_BITS;
  localparam int CNT_W     = $clog2(MUL_BITS);

  typedef struct packed {
    logic [15:0] lo_mhz;
  } sdc_req_t;

  typedef struct packed {
    logic [2:0]  div_exponent;
    logic [8:0]  int_ratio;
    logic [15:0] frac_high;
    logic [7:0]  frac_low;
    logic [1:0]  prescale_sel;
    logic [1:0]  pump_current;
    logic [35:0] achieved_hz;
    logic        bad_input;
  } sdc_res_t;

  typedef struct packed {
    logic idle;
    logic done;
  } sdc_status_t;

endpackage

`default_nettype wire

// ===== design/sdc_stream_if.sv =====
// valid/ready channel carrying one request or result payload
// payload type is supplied per instance, normally from sdc_pkg
`default_nettype none

interface sdc_stream_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/synth_divider_calc_unit.sv =====
// synthesizer divider calculation: one LO frequency request in, one settings result out.
// req carries lo_mhz (MHz); res carries exponent, N ratio fields, prescaler, pump, achieved Hz.
// both channels are valid/ready; a request or result moves when valid and ready are high.
// one request is worked at a time: req.ready is high only while the core is idle.
// a zero frequency goes from idle straight to done with bad_input set. any other request
// runs the exponent search for e, the output divider exponent (0 to 5), then the two-step
// reciprocal divide by five, then the shift-add multiply for the achieved frequency, which
// works through the 17 bits of the multiplier constant one bit at a time.
// the result sits in an output register; the core takes the next request while it waits.
// if res stalls, a second finished result holds in the core until the register frees.
// rst (synchronous, active high) returns the sequencer to idle and empties the output register.
// depends on sdc_pkg, sdc_stream_if and sdc_core
`default_nettype none

module synth_divider_calc_unit (
  input wire logic     clk,
  input wire logic     rst,
  sdc_stream_if.sink   req,
  sdc_stream_if.source res
);

  sdc_pkg::sdc_status_t status;
  sdc_pkg::sdc_res_t    core_res;
  sdc_pkg::sdc_res_t    out_data;
  logic                 out_valid;
  logic                 take;
  logic                 start;

  assign req.ready = status.idle;
  assign start     = req.valid && status.idle;
  assign take      = !out_valid || res.ready;

  sdc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .lo_mhz (req.data.lo_mhz),
    .take   (take),
    .status (status),
    .result (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (status.done && take) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (status.done && take) begin
      out_data <= core_res;
    end
  end

  assign res.valid = out_valid;
  assign res.data  = out_data;

endmodule

`default_nettype wire

// ===== design/sdc_core.sv =====
// sequenced datapath: exponent search, reciprocal divide by five, shift-add multiply
// depends on sdc_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module sdc_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [15:0]         lo_mhz,
  input  wire logic                take,
  output sdc_pkg::sdc_status_t     status,
  output sdc_pkg::sdc_res_t        result
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXP  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  localparam int DW = sdc_pkg::DIV_BITS;
  localparam int FW = sdc_pkg::FRAC_W;
  localparam int AW = sdc_pkg::ACC_W;
  localparam int CW = sdc_pkg::CNT_W;

  logic [2:0]    state;
  logic [CW-1:0] cnt;
  logic          bad;
  logic [2:0]    expo;
  logic [20:0]   lo_sh;
  logic          sel;
  logic [13:0]   q5;
  logic [DW-1:0] quo;
  logic [AW-1:0] mreg;
  logic [AW-1:0] acc;

  logic [20:0]   lo_dbl;
  logic          exp_go;
  logic [15:0]   fvco;
  logic          fvco_high;
  logic [31:0]   recip_prod;
  logic [13:0]   q5_calc;
  logic [15:0]   q5_x5;
  logic [15:0]   r5_full;
  logic [2:0]    r5;
  logic [23:0]   frac_lo24;
  logic [24:0]   frac_lo25;
  logic [DW-1:0] quo_calc;
  logic [4:0]    hz_shamt;
  logic [AW-1:0] hz_full;

  // lo * 2^(e+1) <= 5400 is the same test as floor(5400 / lo) >= 2^(e+1)
  assign lo_dbl    = {lo_sh[19:0], 1'b0};
  assign exp_go    = (expo < sdc_pkg::MAX_EXP) && (lo_dbl <= {8'd0, sdc_pkg::TOP_MHZ});
  assign fvco      = lo_sh[15:0];
  assign fvco_high = fvco > sdc_pkg::HIGH_VCO;

  // fvco / 5 as (fvco * 52429) >> 18, exact for 16-bit fvco
  assign recip_prod = {16'd0, fvco} * {16'd0, sdc_pkg::RECIP5};
  assign q5_calc    = recip_prod[31:18];
  assign q5_x5      = {q5, 2'b00} + {2'b00, q5};
  assign r5_full    = fvco - q5_x5;
  assign r5         = r5_full[2:0];

  // (5q + r) << k over five is q << k plus floor((r << k) / 5)
  always_comb begin
    unique case (r5)
      3'd1: begin
        frac_lo24 = 24'h333333;
        frac_lo25 = 25'h0666666;
      end
      3'd2: begin
        frac_lo24 = 24'h666666;
        frac_lo25 = 25'h0cccccc;
      end
      3'd3: begin
        frac_lo24 = 24'h999999;
        frac_lo25 = 25'h1333333;
      end
      3'd4: begin
        frac_lo24 = 24'hcccccc;
        frac_lo25 = 25'h1999999;
      end
      default: begin
        frac_lo24 = 24'd0;
        frac_lo25 = 25'd0;
      end
    endcase
  end

  // fvco << 29 over 80 or 160 is fvco << 25 or << 24 over five
  assign quo_calc = sel ? {3'd0, q5, frac_lo24} : {2'd0, q5, frac_lo25};

  // achieved hz = (frac24 * 78125) >> (14 + expo - sel)
  assign hz_shamt = sdc_pkg::HZ_SHIFT_BASE + {2'd0, expo} - {4'd0, sel};
  assign hz_full  = acc >> hz_shamt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            state <= (lo_mhz == 16'd0) ? ST_DONE : ST_EXP;
          end
        end
        ST_EXP: begin
          if (!exp_go) begin
            cnt   <= '0;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (cnt == CW'(sdc_pkg::DIV_STEPS - 1)) begin
            cnt   <= '0;
            state <= ST_MUL;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_MUL: begin
          if (cnt == CW'(sdc_pkg::MUL_BITS - 1)) begin
            cnt   <= '0;
            state <= ST_DONE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_DONE: begin
          if (take) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          bad   <= lo_mhz == 16'd0;
          lo_sh <= {5'd0, lo_mhz};
          expo  <= 3'd0;
        end
      end
      ST_EXP: begin
        if (exp_go) begin
          lo_sh <= lo_dbl;
          expo  <= expo + 3'd1;
        end else begin
          sel <= fvco_high;
        end
      end
      ST_DIV: begin
        if (cnt == CW'(sdc_pkg::DIV_STEPS - 1)) begin
          quo  <= quo_calc;
          mreg <= {{sdc_pkg::MUL_BITS{1'b0}}, quo_calc[DW-1:5]};
          acc  <= '0;
        end else begin
          q5 <= q5_calc;
        end
      end
      ST_MUL: begin
        if (sdc_pkg::HZ_MULT[cnt]) begin
          acc <= acc + mreg;
        end
        mreg <= {mreg[AW-2:0], 1'b0};
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result = '0;
    if (bad) begin
      result.bad_input = 1'b1;
    end else begin
      result.div_exponent = expo;
      result.int_ratio    = quo[37:29];
      result.frac_high    = quo[28:13];
      result.frac_low     = quo[12:5];
      result.prescale_sel = sel ? 2'd2 : 2'd1;
      result.pump_current = sel ? 2'd3 : 2'd2;
      result.achieved_hz  = hz_full[35:0];
    end
  end

  assign status.idle = state == ST_IDLE;
  assign status.done = state == ST_DONE;

  `SDC_ASSERT_ALWAYS(a_rem_range, clk, rst, (state != ST_DIV) || (cnt != CW'(sdc_pkg::DIV_STEPS - 1)) || (r5_full <= 16'd4))
  `SDC_ASSERT_ALWAYS(a_expo_cap, clk, rst, (state == ST_IDLE) || (expo <= sdc_pkg::MAX_EXP))
  `SDC_ASSERT_NEXT(a_exp_exit, clk, rst, state == ST_EXP, (state == ST_EXP) || (state == ST_DIV))
  `SDC_ASSERT_NEXT(a_done_hold, clk, rst, (state == ST_DONE) && !take, state == ST_DONE)

endmodule

`default_nettype wire

// ===== sim/tb_synth_divider_calc_unit.sv =====
// testbench for synth_divider_calc_unit: directed table, then random lo frequency requests
// each result is checked against a local divider settings calculation or a typed table entry, with random stalls
// depends on sdc_pkg, sdc_stream_if and the synth_divider_calc_unit rtl
`timescale 1ns / 100ps

module tb_synth_divider_calc_unit;

  localparam int unsigned RAND_N      = 1680;
  localparam int unsigned TAIL_N      = 150;
  localparam int unsigned HOLD_AT     = 300;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_WAIT  = 80;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  localparam longint unsigned REF_MHZ    = 40;
  localparam longint unsigned HZ_PER_MHZ = 1000000;
  localparam int unsigned     FRAC_SHIFT = 29;

  typedef struct packed {
    logic [15:0]       lo;
    logic              typed;
    sdc_pkg::sdc_res_t want;
  } dir_row_t;

  localparam sdc_pkg::sdc_res_t BAD_RES =
    '{3'd0, 9'd0, 16'd0, 8'd0, 2'd0, 2'd0, 36'd0, 1'b1};

  localparam int DIR_N = 22;
  localparam dir_row_t DIR_TAB [DIR_N] = '{
    '{16'd0,     1'b1, BAD_RES},
    '{16'd1,     1'b1, '{3'd5, 9'd0, 16'd26214, 8'd102, 2'd1, 2'd2, 36'd999999, 1'b0}},
    '{16'd65535, 1'b1, '{3'd0, 9'd409, 16'd38912, 8'd0, 2'd2, 2'd3, 36'd65535000000, 1'b0}},
    '{16'd2,     1'b0, '0},
    '{16'd3,     1'b0, '0},
    '{16'd168,   1'b0, '0},
    '{16'd169,   1'b0, '0},
    '{16'd1350,  1'b0, '0},
    '{16'd1600,  1'b0, '0},
    '{16'd1601,  1'b0, '0},
    '{16'd2700,  1'b0, '0},
    '{16'd2701,  1'b0, '0},
    '{16'd3200,  1'b0, '0},
    '{16'd3201,  1'b0, '0},
    '{16'd5400,  1'b0, '0},
    '{16'd5401,  1'b0, '0},
    '{16'h5555,  1'b0, '0},
    '{16'haaaa,  1'b0, '0},
    '{16'h7fff,  1'b0, '0},
    '{16'h8000,  1'b0, '0},
    '{16'd100,   1'b0, '0},
    '{16'd0,     1'b1, BAD_RES}
  };

  logic clk;
  logic rst;

  sdc_stream_if #(.data_t(sdc_pkg::sdc_req_t)) req_ch ();
  sdc_stream_if #(.data_t(sdc_pkg::sdc_res_t)) res_ch ();

  synth_divider_calc_unit uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .res(res_ch)
  );

  sdc_pkg::sdc_res_t settings_due [$];
  int unsigned       fail_count  = 0;
  bit                drain_phase = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic sdc_pkg::sdc_res_t calc_settings(input logic [15:0] lo);
    sdc_pkg::sdc_res_t s;
    int unsigned       quot;
    int unsigned       expo;
    longint unsigned   lodiv;
    longint unsigned   fvco;
    longint unsigned   fbk;
    longint unsigned   ratio;
    longint unsigned   frac24;
    s = '0;
    if (lo == 16'd0) begin
      s.bad_input = 1'b1;
    end else begin
      quot = sdc_pkg::TOP_MHZ / lo;
      expo = 0;
      while (quot > 1 && expo < sdc_pkg::MAX_EXP) begin
        expo++;
        quot >>= 1;
      end
      lodiv = 64'd1 << expo;
      fvco  = (lodiv * lo) & 64'hffff;
      fbk   = (fvco > sdc_pkg::HIGH_VCO) ? 64'd4 : 64'd2;
      ratio  = (fvco << FRAC_SHIFT) / (fbk * REF_MHZ);
      frac24 = ratio >> 5;
      s.div_exponent = expo[2:0];
      s.int_ratio    = ratio[37:29];
      s.frac_high    = ratio[28:13];
      s.frac_low     = frac24[7:0];
      s.prescale_sel = fbk[2:1];
      s.pump_current = (fbk == 64'd4) ? 2'd3 : 2'd2;
      s.achieved_hz  = 36'((REF_MHZ * frac24 * fbk * HZ_PER_MHZ) / (lodiv << 24));
    end
    return s;
  endfunction

  // mostly in-band frequencies, with divider and vco band edges, zeros, out-of-band values and full-range noise
  function automatic logic [15:0] pick_lo();
    int unsigned sel;
    int unsigned base;
    sel = $urandom_range(0, 11);
    case (sel)
      0, 1, 2, 3: begin
        pick_lo = 16'($urandom_range(1, 5400));
      end
      4: begin
        pick_lo = 16'($urandom_range(1, 200));
      end
      5, 6: begin
        pick_lo = 16'($urandom_range(0, 65535));
      end
      7, 8: begin
        base = ($urandom_range(0, 1) == 0) ? 5400 : 3200;
        base = base >> $urandom_range(0, 6);
        pick_lo = 16'(base + $urandom_range(0, 4) - 2);
      end
      9: begin
        pick_lo = 16'd0;
      end
      default: begin
        pick_lo = 16'($urandom_range(5401, 65535));
      end
    endcase
  endfunction

  task automatic offer_lo(input logic [15:0] lo, input sdc_pkg::sdc_res_t want);
    req_ch.valid       <= 1'b1;
    req_ch.data.lo_mhz <= lo;
    do @(posedge clk); while (!req_ch.ready);
    settings_due.push_back(want);
  endtask

  task automatic idle_req(input int unsigned gap);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic check_settings(input sdc_pkg::sdc_res_t got, input sdc_pkg::sdc_res_t want);
    if (got.div_exponent !== want.div_exponent) begin
      $error("div_exponent: expected %0d, got %0d", want.div_exponent, got.div_exponent);
      fail_count++;
    end
    if (got.int_ratio !== want.int_ratio) begin
      $error("int_ratio: expected %0d, got %0d", want.int_ratio, got.int_ratio);
      fail_count++;
    end
    if (got.frac_high !== want.frac_high) begin
      $error("frac_high: expected %0d, got %0d", want.frac_high, got.frac_high);
      fail_count++;
    end
    if (got.frac_low !== want.frac_low) begin
      $error("frac_low: expected %0d, got %0d", want.frac_low, got.frac_low);
      fail_count++;
    end
    if (got.prescale_sel !== want.prescale_sel) begin
      $error("prescale_sel: expected %0d, got %0d", want.prescale_sel, got.prescale_sel);
      fail_count++;
    end
    if (got.pump_current !== want.pump_current) begin
      $error("pump_current: expected %0d, got %0d", want.pump_current, got.pump_current);
      fail_count++;
    end
    if (got.achieved_hz !== want.achieved_hz) begin
      $error("achieved_hz: expected %0d, got %0d", want.achieved_hz, got.achieved_hz);
      fail_count++;
    end
    if (got.bad_input !== want.bad_input) begin
      $error("bad_input: expected %0d, got %0d", want.bad_input, got.bad_input);
      fail_count++;
    end
  endtask

  // request side
  initial begin
    logic [15:0] lo;
    bit          calm;
    rst          <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.data  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_N; i++) begin
      if ($urandom_range(0, 2) == 0) begin
        idle_req($urandom_range(1, 14));
      end
      offer_lo(DIR_TAB[i].lo,
               DIR_TAB[i].typed ? DIR_TAB[i].want : calc_settings(DIR_TAB[i].lo));
    end

    calm = 1'b0;
    for (int i = 0; i < RAND_N; i++) begin
      drain_phase = (i >= RAND_N - TAIL_N);
      if (i % 64 == 0) begin
        calm = ($urandom_range(0, 2) == 0);
      end
      if (!drain_phase && !calm && $urandom_range(0, 3) == 0) begin
        idle_req($urandom_range(1, 14));
      end
      lo = pick_lo();
      offer_lo(lo, calc_settings(lo));
    end
    req_ch.valid <= 1'b0;

    while (settings_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // result side: random stall bursts, one long hold-off so the core backs up
  initial begin
    int unsigned stall_left;
    int unsigned hold_left;
    int unsigned res_count;
    int unsigned calm_left;
    bit          calm;
    stall_left = 0;
    hold_left  = 0;
    res_count  = 0;
    calm_left  = 0;
    calm       = 1'b0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid && res_ch.ready) begin
        if (settings_due.size() == 0) begin
          $error("result with no request outstanding");
          fail_count++;
        end else begin
          check_settings(res_ch.data, settings_due.pop_front());
        end
        res_count++;
        if (res_count == HOLD_AT) begin
          hold_left = HOLD_CYCLES;
        end
      end

      if (calm_left == 0) begin
        calm      = ($urandom_range(0, 2) == 0);
        calm_left = $urandom_range(50, 400);
      end else begin
        calm_left--;
      end

      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else if (!drain_phase && !calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 14) - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
